>>> rtl/ksi_pkg.sv
// Shared sizes, codes and divider interface types for the keyframe servo interpolator.
// Used by ksi_divider and keyframe_servo_interpolator; depends on nothing else.
package ksi_pkg;

   localparam int FRAMES    = 3;
   localparam int SERVOS    = 3;
   localparam int FRM_W     = $clog2(FRAMES);
   localparam int SRV_W     = (SERVOS > 1) ? $clog2(SERVOS) : 1;
   localparam int KEY_DEPTH = FRAMES * SERVOS;
   localparam int KEY_AW    = $clog2(KEY_DEPTH);

   localparam int ANG_W  = 8;
   localparam int DUR_W  = 24;
   localparam int CTR_W  = 30;
   localparam int TOT_W  = 30;
   localparam int POS_W  = 16;
   localparam int PROD_W = ANG_W + DUR_W;

   localparam int DIV_W     = 30;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam int LERP_STEPS = POS_W;

   typedef enum logic [1:0] {
      OP_KEY     = 2'd0,
      OP_DUR     = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_SET     = 2'd3
   } op_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     rem_init;
      logic [DIV_W-1:0]     numer;
      logic [DIV_W-1:0]     divisor;
      logic [DIV_CNT_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
      logic [DIV_W-1:0] rem;
   } div_rsp_type;

endpackage

>>> rtl/ksi_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Shared by the counter modulo and the per-servo interpolation; uses ksi_pkg.
module ksi_divider (
   input  logic                clock,
   input  logic                reset,
   input  ksi_pkg::div_req_type div_req,
   output ksi_pkg::div_rsp_type div_rsp
);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [ksi_pkg::DIV_W-1:0]     rem_ff, rem_in;
   logic [ksi_pkg::DIV_W-1:0]     num_ff, num_in;
   logic [ksi_pkg::DIV_W-1:0]     quot_ff, quot_in;
   logic [ksi_pkg::DIV_W-1:0]     dvs_ff, dvs_in;
   logic [ksi_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ksi_pkg::DIV_W:0]       shifted;
   logic [ksi_pkg::DIV_W:0]       trial;

   assign shifted = {rem_ff, num_ff[ksi_pkg::DIV_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      if (div_req.start) begin
         run_in  = 1'b1;
         rem_in  = div_req.rem_init;
         num_in  = div_req.numer;
         quot_in = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = div_req.steps;
      end else if (run_ff) begin
         // keep the trial difference when it does not borrow
         if (!trial[ksi_pkg::DIV_W]) begin
            rem_in = trial[ksi_pkg::DIV_W-1:0];
         end else begin
            rem_in = shifted[ksi_pkg::DIV_W-1:0];
         end
         quot_in = {quot_ff[ksi_pkg::DIV_W-2:0], ~trial[ksi_pkg::DIV_W]};
         num_in  = {num_ff[ksi_pkg::DIV_W-2:0], 1'b0};
         cnt_in  = cnt_ff - ksi_pkg::DIV_CNT_W'(1);
         if (cnt_ff == ksi_pkg::DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

>>> rtl/keyframe_servo_interpolator.sv
// Looping keyframe animator: keyframe and duration tables, time counter, per-servo output.
// Depends on ksi_pkg and ksi_divider.
//
// Usage: drive req_* with start high; the item is taken at an edge where busy is low.
// Keyframe writes and counter sets never raise busy. A duration
// write holds busy for one cycle while the running total is updated from the table.
// An advance emits one result per servo on rsp_*, each valid for exactly one cycle
// with rsp_valid high, servo 0 first, rsp_last on the final one. The receiver cannot
// stall, so results are never held. With a zero total duration an advance skips the
// counter modulo and segment search; otherwise it runs the 30-step counter modulo,
// then reads and compares each segment up to the one it stops at. Per servo it does
// two table reads and, for a nonzero segment duration, the 16-step serial divide.
// Reset clears the counter and the running total, then busy stays high for a
// clearing pass over all FRAMES*SERVOS key addresses that zeroes both tables.
module keyframe_servo_interpolator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [5:0]  req_frame_index,
   input  logic [3:0]  req_servo_index,
   input  logic [7:0]  req_key_angle,
   input  logic [23:0] req_amount,
   output logic        rsp_valid,
   output logic [3:0]  rsp_servo_id,
   output logic [15:0] rsp_position,
   output logic [5:0]  rsp_segment,
   output logic        rsp_last,
   output logic        rsp_no_duration
);

   typedef enum logic [10:0] {
      ST_CLEAR      = 11'b000_0000_0001,
      ST_IDLE       = 11'b000_0000_0010,
      ST_DUR_WR     = 11'b000_0000_0100,
      ST_MOD_RUN    = 11'b000_0000_1000,
      ST_SEG_RD     = 11'b000_0001_0000,
      ST_SEG_CMP    = 11'b000_0010_0000,
      ST_KEY_RD_CUR = 11'b000_0100_0000,
      ST_KEY_RD_NXT = 11'b000_1000_0000,
      ST_KEY_MUL    = 11'b001_0000_0000,
      ST_LERP_LOAD  = 11'b010_0000_0000,
      ST_LERP_RUN   = 11'b100_0000_0000
   } state_type;

   state_type                     state_ff, state_in;
   logic [ksi_pkg::KEY_AW-1:0]    clr_ff, clr_in;
   logic [ksi_pkg::CTR_W-1:0]     counter_ff, counter_in;
   logic [ksi_pkg::TOT_W-1:0]     total_ff, total_in;
   logic [ksi_pkg::FRM_W-1:0]     frame_ff, frame_in;
   logic [ksi_pkg::DUR_W-1:0]     amount_ff, amount_in;
   logic [ksi_pkg::CTR_W-1:0]     off_ff, off_in;
   logic [ksi_pkg::FRM_W-1:0]     seg_ff, seg_in;
   logic [ksi_pkg::KEY_AW-1:0]    base_ff, base_in;
   logic [ksi_pkg::SRV_W-1:0]     servo_ff, servo_in;
   logic [ksi_pkg::DUR_W-1:0]     seg_dur_ff, seg_dur_in;
   logic                          none_ff, none_in;
   logic [ksi_pkg::ANG_W-1:0]     key_cur_ff, key_cur_in;
   logic                          neg_ff, neg_in;
   logic [ksi_pkg::PROD_W-1:0]    prod_ff, prod_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [3:0]                    rsp_servo_ff, rsp_servo_in;
   logic [ksi_pkg::POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [5:0]                    rsp_seg_ff, rsp_seg_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_none_ff, rsp_none_in;

   logic [ksi_pkg::ANG_W-1:0]     key_mem [ksi_pkg::KEY_DEPTH];
   logic [ksi_pkg::DUR_W-1:0]     dur_mem [ksi_pkg::FRAMES];
   logic [ksi_pkg::ANG_W-1:0]     key_rdata_ff;
   logic [ksi_pkg::DUR_W-1:0]     dur_rdata_ff;

   logic                          key_we;
   logic [ksi_pkg::KEY_AW-1:0]    key_waddr;
   logic [ksi_pkg::ANG_W-1:0]     key_wdata;
   logic [ksi_pkg::KEY_AW-1:0]    key_raddr;
   logic                          dur_we;
   logic [ksi_pkg::FRM_W-1:0]     dur_waddr;
   logic [ksi_pkg::DUR_W-1:0]     dur_wdata;
   logic [ksi_pkg::FRM_W-1:0]     dur_raddr;

   ksi_pkg::div_req_type          div_req;
   ksi_pkg::div_rsp_type          div_rsp;

   logic                          frame_ok;
   logic                          servo_ok;
   logic [ksi_pkg::KEY_AW-1:0]    req_key_addr;
   logic [ksi_pkg::CTR_W-1:0]     sum;
   logic                          seg_is_last;
   logic                          servo_is_last;
   logic [ksi_pkg::KEY_AW-1:0]    nxt_base;
   logic [ksi_pkg::ANG_W-1:0]     mag;
   logic [ksi_pkg::POS_W-1:0]     base_pos;
   logic [ksi_pkg::POS_W-1:0]     quot16;
   logic                          emit;
   logic [ksi_pkg::POS_W-1:0]     emit_pos;

   ksi_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign frame_ok      = ({1'b0, req_frame_index} < 7'(ksi_pkg::FRAMES));
   assign servo_ok      = ({1'b0, req_servo_index} < 5'(ksi_pkg::SERVOS));
   assign req_key_addr  = ksi_pkg::KEY_AW'(int'(req_frame_index) * ksi_pkg::SERVOS
                                           + int'(req_servo_index));
   assign sum           = ksi_pkg::CTR_W'(counter_ff + ksi_pkg::CTR_W'(req_amount));
   assign seg_is_last   = (seg_ff == ksi_pkg::FRM_W'(ksi_pkg::FRAMES - 1));
   assign servo_is_last = (servo_ff == ksi_pkg::SRV_W'(ksi_pkg::SERVOS - 1));
   assign nxt_base      = seg_is_last ? '0
                          : ksi_pkg::KEY_AW'(base_ff + ksi_pkg::KEY_AW'(ksi_pkg::SERVOS));
   assign mag           = (key_rdata_ff < key_cur_ff) ? (key_cur_ff - key_rdata_ff)
                          : (key_rdata_ff - key_cur_ff);
   assign base_pos      = {key_cur_ff, 8'h00};
   assign quot16        = div_rsp.quot[ksi_pkg::POS_W-1:0];

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      counter_in   = counter_ff;
      total_in     = total_ff;
      frame_in     = frame_ff;
      amount_in    = amount_ff;
      off_in       = off_ff;
      seg_in       = seg_ff;
      base_in      = base_ff;
      servo_in     = servo_ff;
      seg_dur_in   = seg_dur_ff;
      none_in      = none_ff;
      key_cur_in   = key_cur_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      rsp_valid_in = 1'b0;
      rsp_servo_in = rsp_servo_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_none_in  = rsp_none_ff;

      key_we    = 1'b0;
      key_waddr = clr_ff;
      key_wdata = '0;
      key_raddr = ksi_pkg::KEY_AW'(base_ff + ksi_pkg::KEY_AW'(servo_ff));
      dur_we    = 1'b0;
      dur_waddr = clr_ff[ksi_pkg::FRM_W-1:0];
      dur_wdata = '0;
      dur_raddr = seg_ff;

      div_req.start    = 1'b0;
      div_req.rem_init = '0;
      div_req.numer    = sum;
      div_req.divisor  = total_ff;
      div_req.steps    = ksi_pkg::DIV_CNT_W'(ksi_pkg::CTR_W);

      emit     = 1'b0;
      emit_pos = base_pos;

      unique case (state_ff)
         ST_CLEAR: begin
            key_we = 1'b1;
            dur_we = ({1'b0, clr_ff} < (ksi_pkg::KEY_AW + 1)'(ksi_pkg::FRAMES));
            clr_in = ksi_pkg::KEY_AW'(clr_ff + ksi_pkg::KEY_AW'(1));
            if (clr_ff == ksi_pkg::KEY_AW'(ksi_pkg::KEY_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // fetch the old duration now so the total can be corrected next cycle
            dur_raddr = req_frame_index[ksi_pkg::FRM_W-1:0];
            if (start) begin
               unique case (ksi_pkg::op_type'(req_op))
                  ksi_pkg::OP_KEY: begin
                     if (frame_ok && servo_ok) begin
                        key_we    = 1'b1;
                        key_waddr = req_key_addr;
                        key_wdata = req_key_angle;
                     end
                  end
                  ksi_pkg::OP_DUR: begin
                     if (frame_ok) begin
                        frame_in  = req_frame_index[ksi_pkg::FRM_W-1:0];
                        amount_in = req_amount;
                        state_in  = ST_DUR_WR;
                     end
                  end
                  ksi_pkg::OP_SET: begin
                     counter_in = ksi_pkg::CTR_W'(req_amount);
                  end
                  ksi_pkg::OP_ADVANCE: begin
                     seg_in   = '0;
                     base_in  = '0;
                     servo_in = '0;
                     if (total_ff == '0) begin
                        counter_in = sum;
                        none_in    = 1'b1;
                        state_in   = ST_KEY_RD_CUR;
                     end else begin
                        none_in       = 1'b0;
                        div_req.start = 1'b1;
                        state_in      = ST_MOD_RUN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DUR_WR: begin
            dur_we    = 1'b1;
            dur_waddr = frame_ff;
            dur_wdata = amount_ff;
            total_in  = ksi_pkg::TOT_W'(total_ff - ksi_pkg::TOT_W'(dur_rdata_ff)
                                        + ksi_pkg::TOT_W'(amount_ff));
            state_in  = ST_IDLE;
         end
         ST_MOD_RUN: begin
            if (div_rsp.done) begin
               counter_in = div_rsp.rem;
               off_in     = div_rsp.rem;
               state_in   = ST_SEG_RD;
            end
         end
         ST_SEG_RD: begin
            state_in = ST_SEG_CMP;
         end
         ST_SEG_CMP: begin
            if ((off_ff < ksi_pkg::CTR_W'(dur_rdata_ff)) || seg_is_last) begin
               seg_dur_in = dur_rdata_ff;
               state_in   = ST_KEY_RD_CUR;
            end else begin
               off_in   = off_ff - ksi_pkg::CTR_W'(dur_rdata_ff);
               seg_in   = ksi_pkg::FRM_W'(seg_ff + ksi_pkg::FRM_W'(1));
               base_in  = ksi_pkg::KEY_AW'(base_ff + ksi_pkg::KEY_AW'(ksi_pkg::SERVOS));
               state_in = ST_SEG_RD;
            end
         end
         ST_KEY_RD_CUR: begin
            state_in = ST_KEY_RD_NXT;
         end
         ST_KEY_RD_NXT: begin
            key_cur_in = key_rdata_ff;
            key_raddr  = ksi_pkg::KEY_AW'(nxt_base + ksi_pkg::KEY_AW'(servo_ff));
            state_in   = ST_KEY_MUL;
         end
         ST_KEY_MUL: begin
            neg_in  = (key_rdata_ff < key_cur_ff);
            prod_in = ksi_pkg::PROD_W'(mag) * ksi_pkg::PROD_W'(off_ff[ksi_pkg::DUR_W-1:0]);
            if (none_ff || (seg_dur_ff == '0)) begin
               emit = 1'b1;
            end else begin
               state_in = ST_LERP_LOAD;
            end
         end
         ST_LERP_LOAD: begin
            // product >> 8 is below the duration, so 16 steps give the whole quotient
            div_req.start    = 1'b1;
            div_req.rem_init = ksi_pkg::DIV_W'(prod_ff[ksi_pkg::PROD_W-1:8]);
            div_req.numer    = {prod_ff[7:0], (ksi_pkg::DIV_W - 8)'(0)};
            div_req.divisor  = ksi_pkg::DIV_W'(seg_dur_ff);
            div_req.steps    = ksi_pkg::DIV_CNT_W'(ksi_pkg::LERP_STEPS);
            state_in         = ST_LERP_RUN;
         end
         ST_LERP_RUN: begin
            if (div_rsp.done) begin
               emit     = 1'b1;
               emit_pos = neg_ff ? (base_pos - quot16) : (base_pos + quot16);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_servo_in = 4'(servo_ff);
         rsp_pos_in   = emit_pos;
         rsp_seg_in   = 6'(seg_ff);
         rsp_last_in  = servo_is_last;
         rsp_none_in  = none_ff;
         if (servo_is_last) begin
            state_in = ST_IDLE;
         end else begin
            servo_in = ksi_pkg::SRV_W'(servo_ff + ksi_pkg::SRV_W'(1));
            state_in = ST_KEY_RD_CUR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         counter_ff   <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         counter_ff   <= counter_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff     <= frame_in;
      amount_ff    <= amount_in;
      off_ff       <= off_in;
      seg_ff       <= seg_in;
      base_ff      <= base_in;
      servo_ff     <= servo_in;
      seg_dur_ff   <= seg_dur_in;
      none_ff      <= none_in;
      key_cur_ff   <= key_cur_in;
      neg_ff       <= neg_in;
      prod_ff      <= prod_in;
      rsp_servo_ff <= rsp_servo_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_none_ff  <= rsp_none_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      key_rdata_ff <= key_mem[key_raddr];
   end

   always_ff @(posedge clock) begin
      if (dur_we) begin
         dur_mem[dur_waddr] <= dur_wdata;
      end
      dur_rdata_ff <= dur_mem[dur_raddr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_servo_id    = rsp_servo_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_segment     = rsp_seg_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_no_duration = rsp_none_ff;

endmodule

>>> dv/tb_keyframe_servo_interpolator.sv
`timescale 1ns / 1ps
// Testbench for keyframe_servo_interpolator: directed and random keyframe, duration,
// set and advance items, with every servo position checked against an in-bench model.
// Depends on ksi_pkg for the table sizes and the op codes.
module tb_keyframe_servo_interpolator;

   localparam int CLK_HALF    = 10;
   localparam int RESET_CYCLES = 12;
   localparam int TAIL_CYCLES = 150;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PER_PHASE = 16;
   localparam int WRAP_ADVANCES = 70;

   typedef struct {
      ksi_pkg::op_type op;
      logic [5:0]  frame;
      logic [3:0]  servo;
      logic [7:0]  angle;
      logic [23:0] amount;
      int          gap_pct;
   } servo_cmd_type;

   typedef struct {
      logic [3:0]  servo_id;
      logic [15:0] position;
      logic [5:0]  segment;
      logic        last;
      logic        no_duration;
   } servo_pos_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = ksi_pkg::OP_KEY;
   logic [5:0]  req_frame_index = '0;
   logic [3:0]  req_servo_index = '0;
   logic [7:0]  req_key_angle = '0;
   logic [23:0] req_amount = '0;
   logic        rsp_valid;
   logic [3:0]  rsp_servo_id;
   logic [15:0] rsp_position;
   logic [5:0]  rsp_segment;
   logic        rsp_last;
   logic        rsp_no_duration;

   keyframe_servo_interpolator dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_frame_index (req_frame_index),
      .req_servo_index (req_servo_index),
      .req_key_angle   (req_key_angle),
      .req_amount      (req_amount),
      .rsp_valid       (rsp_valid),
      .rsp_servo_id    (rsp_servo_id),
      .rsp_position    (rsp_position),
      .rsp_segment     (rsp_segment),
      .rsp_last        (rsp_last),
      .rsp_no_duration (rsp_no_duration)
   );

   servo_cmd_type cmd_q[$];
   servo_pos_type positions_due[$];
   logic [7:0]  key_angles [ksi_pkg::KEY_DEPTH];
   logic [23:0] seg_durations [ksi_pkg::FRAMES];
   logic [29:0] anim_time = '0;
   bit          item_taken = 1'b0;
   int          mismatches = 0;
   int          cycle_count = 0;

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic push_cmd(input ksi_pkg::op_type op, input int frame, input int servo,
                           input int angle, input int amount, input int gap_pct);
      servo_cmd_type c;
      c.op      = op;
      c.frame   = 6'(frame);
      c.servo   = 4'(servo);
      c.angle   = 8'(angle);
      c.amount  = 24'(amount);
      c.gap_pct = gap_pct;
      cmd_q.push_back(c);
   endtask

   // Mostly in-range table writes and modest deltas so the animation actually moves.
   task automatic push_random_cmd(input int gap_pct);
      int sel;
      int frame;
      int servo;
      int amount;
      ksi_pkg::op_type op;
      sel    = $urandom_range(99);
      frame  = ($urandom_range(99) < 85) ? $urandom_range(ksi_pkg::FRAMES - 1)
                                         : $urandom_range(63);
      servo  = ($urandom_range(99) < 85) ? $urandom_range(ksi_pkg::SERVOS - 1)
                                         : $urandom_range(15);
      amount = $urandom_range(24'hFFFFFF);
      if (sel < 45) begin
         op = ksi_pkg::OP_ADVANCE;
         sel = $urandom_range(99);
         if (sel < 60)
            amount = $urandom_range(2000);
         else if (sel < 75)
            amount = 0;
      end else if (sel < 70) begin
         op = ksi_pkg::OP_KEY;
      end else if (sel < 85) begin
         op = ksi_pkg::OP_DUR;
         sel = $urandom_range(99);
         if (sel < 70)
            amount = $urandom_range(1000, 1);
         else if (sel < 85)
            amount = 0;
      end else begin
         op = ksi_pkg::OP_SET;
         if ($urandom_range(1))
            amount = $urandom_range(3000);
      end
      push_cmd(op, frame, servo, $urandom_range(255), amount, gap_pct);
   endtask

   function automatic void check_field(input string field, input longint unsigned want,
                                       input logic [15:0] got);
      if (got !== 16'(want)) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   task automatic predict_positions(input servo_cmd_type c);
      longint unsigned total;
      longint unsigned offs;
      longint unsigned dur;
      longint unsigned base;
      longint unsigned key;
      longint unsigned next_key;
      longint unsigned pos;
      logic [29:0] summed;
      int seg;
      int next_seg;
      int f;
      int s;
      bit none;
      servo_pos_type p;
      case (c.op)
         ksi_pkg::OP_KEY: begin
            if (c.frame < ksi_pkg::FRAMES && c.servo < ksi_pkg::SERVOS)
               key_angles[c.frame * ksi_pkg::SERVOS + c.servo] = c.angle;
         end
         ksi_pkg::OP_DUR: begin
            if (c.frame < ksi_pkg::FRAMES)
               seg_durations[c.frame] = c.amount;
         end
         ksi_pkg::OP_SET: begin
            anim_time = 30'(c.amount);
         end
         default: begin
            total = 0;
            for (f = 0; f < ksi_pkg::FRAMES; f++)
               total += 64'(seg_durations[f]);
            summed = anim_time + 30'(c.amount);
            none = (total == 0);
            offs = none ? 64'(summed) : 64'(summed) % total;
            anim_time = 30'(offs);
            seg = 0;
            // walk segments; the last one takes whatever is left
            if (!none) begin
               while (seg < ksi_pkg::FRAMES - 1 && offs >= 64'(seg_durations[seg])) begin
                  offs -= 64'(seg_durations[seg]);
                  seg++;
               end
            end
            next_seg = (seg + 1 < ksi_pkg::FRAMES) ? seg + 1 : 0;
            dur = 64'(seg_durations[seg]);
            for (s = 0; s < ksi_pkg::SERVOS; s++) begin
               key      = 64'(key_angles[seg * ksi_pkg::SERVOS + s]);
               next_key = 64'(key_angles[next_seg * ksi_pkg::SERVOS + s]);
               base     = key * 256;
               if (none)
                  pos = 64'(key_angles[s]) * 256;
               else if (dur == 0)
                  pos = base;
               else if (next_key >= key)
                  pos = base + ((next_key - key) * offs * 256) / dur;
               else
                  pos = base - ((key - next_key) * offs * 256) / dur;
               p.servo_id    = 4'(s);
               p.position    = 16'(pos);
               p.segment     = 6'(seg);
               p.last        = (s == ksi_pkg::SERVOS - 1);
               p.no_duration = none;
               positions_due.push_back(p);
            end
         end
      endcase
   endtask

   always @(negedge clock) begin : driver
      servo_cmd_type nxt;
      // hold the current item until it is taken
      if (!reset && !(start && !item_taken)) begin
         if (cmd_q.size() != 0 && $urandom_range(99) >= cmd_q[0].gap_pct) begin
            nxt = cmd_q.pop_front();
            start           <= 1'b1;
            req_op          <= nxt.op;
            req_frame_index <= nxt.frame;
            req_servo_index <= nxt.servo;
            req_key_angle   <= nxt.angle;
            req_amount      <= nxt.amount;
         end else begin
            start      <= 1'b0;
            req_amount <= 24'($urandom_range(24'hFFFFFF));
         end
      end
   end

   always @(posedge clock) begin : monitor
      servo_pos_type want;
      servo_cmd_type seen;
      if (!reset) begin
         if (rsp_valid) begin
            if (positions_due.size() == 0) begin
               $error("unexpected position: servo_id %0d position %0d", rsp_servo_id,
                      rsp_position);
               mismatches++;
            end else begin
               want = positions_due.pop_front();
               check_field("servo_id", 64'(want.servo_id), 16'(rsp_servo_id));
               check_field("position", 64'(want.position), rsp_position);
               check_field("segment", 64'(want.segment), 16'(rsp_segment));
               check_field("last", 64'(want.last), 16'(rsp_last));
               check_field("no_duration", 64'(want.no_duration), 16'(rsp_no_duration));
            end
         end
         item_taken = start && !busy;
         if (item_taken) begin
            seen.op      = ksi_pkg::op_type'(req_op);
            seen.frame   = req_frame_index;
            seen.servo   = req_servo_index;
            seen.angle   = req_key_angle;
            seen.amount  = req_amount;
            seen.gap_pct = 0;
            predict_positions(seen);
         end
      end
   end

   initial begin : stimulus
      int phase_gap [4];
      int p;
      int n;
      foreach (key_angles[i])
         key_angles[i] = '0;
      foreach (seg_durations[i])
         seg_durations[i] = '0;
      phase_gap = '{0, 49, 0, 18};

      // empty tables: zero total, keyframe 0 angles
      push_cmd(ksi_pkg::OP_ADVANCE, 0, 0, 0, 0, 0);
      push_cmd(ksi_pkg::OP_KEY, 0, 0, 255, 0, 0);
      push_cmd(ksi_pkg::OP_KEY, 0, 1, 1, 0, 0);
      push_cmd(ksi_pkg::OP_KEY, 1, 0, 0, 0, 0);
      push_cmd(ksi_pkg::OP_KEY, 1, 1, 255, 0, 0);
      push_cmd(ksi_pkg::OP_KEY, 2, 2, 200, 0, 0);
      // out-of-range table writes are dropped
      push_cmd(ksi_pkg::OP_KEY, 63, 15, 77, 24'hFFFFFF, 0);
      push_cmd(ksi_pkg::OP_KEY, ksi_pkg::FRAMES, 0, 99, 0, 0);
      push_cmd(ksi_pkg::OP_KEY, 0, ksi_pkg::SERVOS, 99, 0, 0);
      push_cmd(ksi_pkg::OP_SET, 0, 0, 0, 24'hFFFFFF, 0);
      push_cmd(ksi_pkg::OP_ADVANCE, 0, 0, 0, 24'hFFFFFF, 0);
      push_cmd(ksi_pkg::OP_DUR, 63, 15, 255, 5, 0);
      push_cmd(ksi_pkg::OP_DUR, ksi_pkg::FRAMES, 0, 0, 5, 0);
      push_cmd(ksi_pkg::OP_DUR, 0, 0, 0, 24'hFFFFFF, 0);
      push_cmd(ksi_pkg::OP_DUR, 1, 0, 0, 1, 0);
      push_cmd(ksi_pkg::OP_DUR, 2, 0, 0, 100, 0);
      push_cmd(ksi_pkg::OP_ADVANCE, 0, 0, 0, 0, 0);
      push_cmd(ksi_pkg::OP_SET, 0, 0, 0, 24'hFFFFFE, 0);
      push_cmd(ksi_pkg::OP_ADVANCE, 0, 0, 0, 1, 0);
      push_cmd(ksi_pkg::OP_ADVANCE, 0, 0, 0, 50, 0);
      push_cmd(ksi_pkg::OP_ADVANCE, 0, 0, 0, 24'hFFFFFF, 0);
      // zero-length middle segment gets stepped over
      push_cmd(ksi_pkg::OP_DUR, 1, 0, 0, 0, 0);
      push_cmd(ksi_pkg::OP_SET, 0, 0, 0, 0, 0);
      push_cmd(ksi_pkg::OP_ADVANCE, 0, 0, 0, 24'hFFFFFF, 0);

      for (p = 0; p < 4; p++) begin
         if (p == 3) begin
            // clear all durations and run the counter past 30 bits
            for (n = 0; n < ksi_pkg::FRAMES; n++)
               push_cmd(ksi_pkg::OP_DUR, n, $urandom_range(15), $urandom_range(255), 0,
                        phase_gap[p]);
            push_cmd(ksi_pkg::OP_SET, 0, 0, 0, 24'hFFFFFF, phase_gap[p]);
            for (n = 0; n < WRAP_ADVANCES; n++)
               push_cmd(ksi_pkg::OP_ADVANCE, $urandom_range(63), $urandom_range(15),
                        $urandom_range(255), $urandom_range(24'hFFFFFF, 24'hF00000),
                        phase_gap[p]);
         end
         for (n = 0; n < RANDOM_PER_PHASE; n++)
            push_random_cmd(phase_gap[p]);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (cmd_q.size() != 0 || start);
      do @(negedge clock); while (positions_due.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
rtl/ksi_pkg.sv
rtl/ksi_divider.sv
rtl/keyframe_servo_interpolator.sv
dv/tb_keyframe_servo_interpolator.sv
